// ===== src/rpba_pkg.sv =====
// ----------------------------------------------------------------------------
// rpba_pkg
// Shared sizes, codes and types of the random-pick block allocator.
// ----------------------------------------------------------------------------
package rpba_pkg;

   // store geometry
   localparam int MaxBlocks  = 1024;
   localparam int MaxVolumes = 8;
   localparam int BlockW     = $clog2(MaxBlocks);
   localparam int CountW     = BlockW + 1;
   localparam int VolW       = 3;
   localparam int MapAddrW   = VolW + BlockW;
   localparam int MapDepth   = MaxVolumes * MaxBlocks;
   localparam int WordW      = 32;
   localparam int OffsetW    = 63;
   localparam int CsrIdxW    = 2;

   // operation codes
   localparam logic [1:0] OpRecord  = 2'd0;
   localparam logic [1:0] OpAlloc   = 2'd1;
   localparam logic [1:0] OpRelease = 2'd2;
   localparam logic [1:0] OpLookup  = 2'd3;

   // status codes
   localparam logic [2:0] StOk        = 3'd0;
   localparam logic [2:0] StPoolEmpty = 3'd1;
   localparam logic [2:0] StIllegal   = 3'd2;
   localparam logic [2:0] StClaimed   = 3'd3;
   localparam logic [2:0] StVolEmpty  = 3'd4;
   localparam logic [2:0] StBadVolume = 3'd5;
   localparam logic [2:0] StUnmapped  = 3'd6;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CsrTotalBlocks = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrDataStart   = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrBlockSecs   = 2'd2;

   // one entry of the block map
   typedef struct packed {
      logic              valid;
      logic [BlockW-1:0] blk;
   } map_entry_type;

endpackage

// ===== src/random_pick_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// random_pick_block_allocator_top
// Free-block pool and per-volume block maps held in synchronous memories.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the block map, one entry a
// cycle, with req_stall high; configuration writes are taken during it. For
// an operation the beat cycle issues the reads of the pool and map memories
// (the allocate pick is scaled there by free count times random word), and
// the execute state then writes the entries back and loads the result
// register. req_stall is high in the execute state and stays high while a
// previous result still waits in the result register.
// The last-block mark of a volume is always the entry at its top slot, so
// req_is_last carries no state of its own.
module random_pick_block_allocator_top (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [rpba_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [rpba_pkg::WordW-1:0]         csr_wdata,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_op,
   input  logic [rpba_pkg::VolW-1:0]          req_volume,
   input  logic [rpba_pkg::BlockW-1:0]        req_phys_block,
   input  logic                               req_claimed,
   input  logic signed [rpba_pkg::WordW-1:0]  req_logical_number,
   input  logic                               req_is_last,
   input  logic [rpba_pkg::WordW-1:0]         req_random_word,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic [rpba_pkg::BlockW-1:0]        rsp_result_block,
   output logic [rpba_pkg::BlockW-1:0]        rsp_prev_last_block,
   output logic                               rsp_prev_last_valid,
   output logic [rpba_pkg::BlockW-1:0]        rsp_new_logical_index,
   output logic [rpba_pkg::OffsetW-1:0]       rsp_sector_offset,
   output logic [rpba_pkg::CountW-1:0]        rsp_pool_count,
   output logic [rpba_pkg::CountW-1:0]        rsp_volume_count
);

   localparam int BW = rpba_pkg::BlockW;
   localparam int CW = rpba_pkg::CountW;
   localparam int AW = rpba_pkg::MapAddrW;
   localparam int VW = rpba_pkg::VolW;
   localparam int WW = rpba_pkg::WordW;
   localparam int MulW = BW + WW;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   // configuration registers
   logic [CW-1:0] total_ff;
   logic [WW-1:0] start_ff;
   logic [WW-1:0] bsec_ff;

   // control and state registers
   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic [CW-1:0] fc_ff, fc_in;
   logic [CW-1:0] size_ff [rpba_pkg::MaxVolumes];
   logic [CW-1:0] size_in;

   // captured request
   logic [1:0]    op_ff;
   logic [VW-1:0] vol_ff;
   logic [BW-1:0] pblk_ff;
   logic          claimed_ff;
   logic [WW-1:0] lnum_ff;
   logic [BW-1:0] pick_ff;

   // memories and their read registers
   logic [BW-1:0]                  pool_mem [rpba_pkg::MaxBlocks];
   rpba_pkg::map_entry_type        map_mem  [rpba_pkg::MapDepth];
   logic [BW-1:0]                  pool_rd0_ff, pool_rd1_ff;
   rpba_pkg::map_entry_type        map_rda_ff, map_rdb_ff;

   // response registers
   logic                  rsp_valid_ff;
   logic [2:0]            status_ff, status_in;
   logic [BW-1:0]         rblk_ff, rblk_in;
   logic [BW-1:0]         plast_ff, plast_in;
   logic                  pvalid_ff, pvalid_in;
   logic [BW-1:0]         nidx_ff, nidx_in;
   logic [rpba_pkg::OffsetW-1:0] soff_ff, soff_in;
   logic [CW-1:0]         pcount_ff;
   logic [CW-1:0]         vcount_ff, vcount_in;

   logic          accept, exec_go, rsp_take;
   logic [CW-1:0] total_eff;
   logic [CW-1:0] acc_size;
   logic [MulW:0] pick_prod;
   logic [BW-1:0] pick_acc;
   logic [BW-1:0] pool_ra0, pool_ra1;
   logic [AW-1:0] map_raa, map_rab;

   logic                    pool_we;
   logic [BW-1:0]           pool_wa, pool_wd;
   logic                    map_we;
   logic [AW-1:0]           map_wa;
   rpba_pkg::map_entry_type map_wd;

   logic [CW-1:0] cur_size;
   logic          vol_ok, lnum_ok;
   logic [CW-1:0] size_m1;
   logic [MulW-1:0] soff_mul;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign exec_go  = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);

   // block count in use, held to 1..MaxBlocks
   always_comb begin
      if (total_ff == '0) begin
         total_eff = CW'(1);
      end else if (total_ff > CW'(rpba_pkg::MaxBlocks)) begin
         total_eff = CW'(rpba_pkg::MaxBlocks);
      end else begin
         total_eff = total_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CW'(rpba_pkg::MaxBlocks);
         start_ff <= '0;
         bsec_ff  <= WW'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            rpba_pkg::CsrTotalBlocks: total_ff <= csr_wdata[CW-1:0];
            rpba_pkg::CsrDataStart:   start_ff <= csr_wdata;
            rpba_pkg::CsrBlockSecs:   bsec_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // read addresses for the beat cycle, pick scaled by free count
   assign acc_size  = size_ff[req_volume];
   assign pick_prod = {{(WW + 1){1'b0}}, fc_ff[BW-1:0]} * {{(BW + 1){1'b0}}, req_random_word};
   assign pick_acc  = fc_ff[BW] ? req_random_word[WW-1 -: BW] : pick_prod[WW +: BW];
   assign pool_ra0  = pick_acc;
   assign pool_ra1  = BW'(fc_ff - CW'(1));

   always_comb begin
      if (req_op == rpba_pkg::OpRecord || req_op == rpba_pkg::OpLookup) begin
         map_raa = {req_volume, req_logical_number[BW-1:0]};
      end else begin
         map_raa = {req_volume, BW'(acc_size - CW'(1))};
      end
      map_rab = {req_volume, BW'(acc_size - CW'(2))};
   end

   // pool memory: one write port, two read ports
   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[pool_wa] <= pool_wd;
      end
      if (accept) begin
         pool_rd0_ff <= pool_mem[pool_ra0];
         pool_rd1_ff <= pool_mem[pool_ra1];
      end
   end

   // block map memory: one write port shared with the clearing pass
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         map_mem[clr_ff] <= '0;
      end else if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (accept) begin
         map_rda_ff <= map_mem[map_raa];
         map_rdb_ff <= map_mem[map_rab];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         vol_ff     <= req_volume;
         pblk_ff    <= req_phys_block;
         claimed_ff <= req_claimed;
         lnum_ff    <= req_logical_number;
         pick_ff    <= pick_acc;
      end
   end

   // operation decode and write-back values
   assign cur_size = size_ff[vol_ff];
   assign vol_ok   = ({1'b0, vol_ff} < (VW + 1)'(rpba_pkg::MaxVolumes));
   assign lnum_ok  = !lnum_ff[WW-1] && (lnum_ff < WW'(total_eff));
   assign size_m1  = cur_size - CW'(1);
   assign soff_mul = {{WW{1'b0}}, map_rda_ff.blk} * {{BW{1'b0}}, bsec_ff};

   always_comb begin
      status_in = rpba_pkg::StOk;
      rblk_in   = '0;
      plast_in  = '0;
      pvalid_in = 1'b0;
      nidx_in   = '0;
      soff_in   = '0;
      fc_in     = fc_ff;
      size_in   = cur_size;
      pool_we   = 1'b0;
      pool_wa   = fc_ff[BW-1:0];
      pool_wd   = pblk_ff;
      map_we    = 1'b0;
      map_wa    = {vol_ff, lnum_ff[BW-1:0]};
      map_wd    = '{valid: 1'b1, blk: pblk_ff};
      unique case (op_ff)
         rpba_pkg::OpRecord: begin
            if (!claimed_ff) begin
               // unclaimed block joins the pool
               if ({1'b0, pblk_ff} >= total_eff || fc_ff >= total_eff) begin
                  status_in = rpba_pkg::StIllegal;
               end else begin
                  pool_we = exec_go;
                  fc_in   = fc_ff + CW'(1);
                  rblk_in = pblk_ff;
               end
            end else if (!vol_ok) begin
               status_in = rpba_pkg::StBadVolume;
            end else if (!lnum_ok || {1'b0, pblk_ff} >= total_eff ||
                         cur_size >= total_eff) begin
               status_in = rpba_pkg::StIllegal;
            end else if (map_rda_ff.valid) begin
               status_in = rpba_pkg::StClaimed;
            end else begin
               map_we  = exec_go;
               size_in = cur_size + CW'(1);
               rblk_in = pblk_ff;
            end
         end
         rpba_pkg::OpAlloc: begin
            if (!vol_ok) begin
               status_in = rpba_pkg::StBadVolume;
            end else if (fc_ff == '0) begin
               status_in = rpba_pkg::StPoolEmpty;
            end else if (cur_size >= total_eff) begin
               status_in = rpba_pkg::StIllegal;
            end else begin
               // append picked block, refill the hole from the pool tail
               if (cur_size != '0 && map_rda_ff.valid) begin
                  plast_in  = map_rda_ff.blk;
                  pvalid_in = 1'b1;
               end
               map_we  = exec_go;
               map_wa  = {vol_ff, cur_size[BW-1:0]};
               map_wd  = '{valid: 1'b1, blk: pool_rd0_ff};
               size_in = cur_size + CW'(1);
               fc_in   = fc_ff - CW'(1);
               pool_we = exec_go;
               pool_wa = pick_ff;
               pool_wd = pool_rd1_ff;
               rblk_in = pool_rd0_ff;
               nidx_in = cur_size[BW-1:0];
            end
         end
         rpba_pkg::OpRelease: begin
            if (!vol_ok) begin
               status_in = rpba_pkg::StBadVolume;
            end else if (cur_size == '0) begin
               status_in = rpba_pkg::StVolEmpty;
            end else if (fc_ff >= total_eff) begin
               status_in = rpba_pkg::StIllegal;
            end else begin
               // drop the top slot, its block goes back to the pool
               if (map_rda_ff.valid) begin
                  pool_we = exec_go;
                  pool_wd = map_rda_ff.blk;
                  fc_in   = fc_ff + CW'(1);
                  rblk_in = map_rda_ff.blk;
               end else begin
                  status_in = rpba_pkg::StUnmapped;
               end
               map_we  = exec_go;
               map_wa  = {vol_ff, size_m1[BW-1:0]};
               map_wd  = '0;
               size_in = size_m1;
               if (size_m1 != '0 && map_rdb_ff.valid) begin
                  plast_in  = map_rdb_ff.blk;
                  pvalid_in = 1'b1;
               end
            end
         end
         rpba_pkg::OpLookup: begin
            if (!vol_ok) begin
               status_in = rpba_pkg::StBadVolume;
            end else if (!lnum_ok) begin
               status_in = rpba_pkg::StIllegal;
            end else if (!map_rda_ff.valid) begin
               status_in = rpba_pkg::StUnmapped;
            end else begin
               rblk_in = map_rda_ff.blk;
               soff_in = rpba_pkg::OffsetW'(soff_mul) + rpba_pkg::OffsetW'(start_ff);
            end
         end
         default: ;
      endcase
      vcount_in = vol_ok ? size_in : '0;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(rpba_pkg::MapDepth - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_EXEC;
         ST_EXEC:  if (exec_go) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   // pool count and volume sizes
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= '0;
         for (int i = 0; i < rpba_pkg::MaxVolumes; i++) begin
            size_ff[i] <= '0;
         end
      end else if (exec_go) begin
         fc_ff <= fc_in;
         if (vol_ok) begin
            size_ff[vol_ff] <= size_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         status_ff <= status_in;
         rblk_ff   <= rblk_in;
         plast_ff  <= plast_in;
         pvalid_ff <= pvalid_in;
         nidx_ff   <= nidx_in;
         soff_ff   <= soff_in;
         pcount_ff <= fc_in;
         vcount_ff <= vcount_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_result_block      = rblk_ff;
   assign rsp_prev_last_block   = plast_ff;
   assign rsp_prev_last_valid   = pvalid_ff;
   assign rsp_new_logical_index = nidx_ff;
   assign rsp_sector_offset     = soff_ff;
   assign rsp_pool_count        = pcount_ff;
   assign rsp_volume_count      = vcount_ff;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the random-pick block allocator. A directed opening
// hits empty pools and volumes, bad slot numbers, occupied slots, holes and
// the widest sector offsets. Random phases under several store sizes follow.
// Every accepted request is run through a local model of the free pool and
// block maps, and each response beat is checked against the oldest predicted
// response.
// ----------------------------------------------------------------------------
module tb;

   localparam int CycleLimit = 400000;

   localparam int MaxBlocks  = rpba_pkg::MaxBlocks;
   localparam int MaxVolumes = rpba_pkg::MaxVolumes;
   localparam int BlockW     = rpba_pkg::BlockW;
   localparam int CountW     = rpba_pkg::CountW;
   localparam int VolW       = rpba_pkg::VolW;
   localparam int WordW      = rpba_pkg::WordW;
   localparam int OffsetW    = rpba_pkg::OffsetW;
   localparam int CsrIdxW    = rpba_pkg::CsrIdxW;

   // one request beat
   typedef struct packed {
      logic [1:0]        op;
      logic [VolW-1:0]   volume;
      logic [BlockW-1:0] phys_block;
      logic              claimed;
      logic [WordW-1:0]  logical_number;
      logic              is_last;
      logic [WordW-1:0]  random_word;
   } alloc_request_type;

   // one response beat
   typedef struct packed {
      logic [2:0]         status;
      logic [BlockW-1:0]  result_block;
      logic [BlockW-1:0]  prev_last_block;
      logic               prev_last_valid;
      logic [BlockW-1:0]  new_logical_index;
      logic [OffsetW-1:0] sector_offset;
      logic [CountW-1:0]  pool_count;
      logic [CountW-1:0]  volume_count;
   } alloc_outcome_type;

   // model of pool and maps plus the queue of responses still owed
   class alloc_scoreboard;
      logic [BlockW-1:0]       pool [MaxBlocks];
      int unsigned             free_blocks;
      rpba_pkg::map_entry_type block_map [MaxVolumes][MaxBlocks];
      int unsigned             vol_blocks [MaxVolumes];
      logic [10:0]             total_reg;
      logic [31:0]             start_reg;
      logic [31:0]             secs_reg;
      alloc_outcome_type       awaited [$];
      int unsigned             mismatches;

      function new();
         total_reg   = 11'd1024;
         start_reg   = '0;
         secs_reg    = 32'd1;
         free_blocks = 0;
         mismatches  = 0;
         for (int b = 0; b < MaxBlocks; b++) begin
            pool[b] = '0;
         end
         for (int v = 0; v < MaxVolumes; v++) begin
            vol_blocks[v] = 0;
            for (int b = 0; b < MaxBlocks; b++) begin
               block_map[v][b] = '0;
            end
         end
      endfunction

      function void set_config(logic [10:0] blocks, logic [31:0] start, logic [31:0] secs);
         total_reg = blocks;
         start_reg = start;
         secs_reg  = secs;
      endfunction

      // store size in use, clamped to 1..MaxBlocks
      function int unsigned effective_total();
         if (total_reg == 0) return 1;
         if (total_reg > MaxBlocks) return MaxBlocks;
         return 32'(total_reg);
      endfunction

      function alloc_outcome_type predict_outcome(alloc_request_type r);
         alloc_outcome_type       o;
         int unsigned             eff;
         int unsigned             v;
         int unsigned             n;
         int unsigned             pick;
         logic                    vol_ok;
         logic                    slot_ok;
         logic [BlockW-1:0]       slot;
         logic [63:0]             prod;
         rpba_pkg::map_entry_type e;
         o       = '0;
         eff     = effective_total();
         v       = 32'(r.volume);
         vol_ok  = (v < MaxVolumes);
         slot_ok = !r.logical_number[WordW-1] && (r.logical_number < eff);
         slot    = r.logical_number[BlockW-1:0];
         case (r.op)
            rpba_pkg::OpRecord: begin
               if (!r.claimed) begin
                  // unclaimed block goes to the pool
                  if (r.phys_block >= eff || free_blocks >= eff) begin
                     o.status = rpba_pkg::StIllegal;
                  end else begin
                     pool[free_blocks] = r.phys_block;
                     free_blocks++;
                     o.result_block = r.phys_block;
                  end
               end else if (!vol_ok) begin
                  o.status = rpba_pkg::StBadVolume;
               end else if (!slot_ok || r.phys_block >= eff || vol_blocks[v] >= eff) begin
                  o.status = rpba_pkg::StIllegal;
               end else if (block_map[v][slot].valid) begin
                  o.status = rpba_pkg::StClaimed;
               end else begin
                  block_map[v][slot] = {1'b1, r.phys_block};
                  vol_blocks[v]++;
                  o.result_block = r.phys_block;
               end
            end
            rpba_pkg::OpAlloc: begin
               if (!vol_ok) begin
                  o.status = rpba_pkg::StBadVolume;
               end else if (free_blocks == 0) begin
                  o.status = rpba_pkg::StPoolEmpty;
               end else if (vol_blocks[v] >= eff) begin
                  o.status = rpba_pkg::StIllegal;
               end else begin
                  // scaled pick, hole refilled from the pool tail
                  n    = vol_blocks[v];
                  prod = 64'(free_blocks) * 64'(r.random_word);
                  pick = prod[63:32];
                  if (pick >= free_blocks) pick = free_blocks - 1;
                  o.result_block = pool[pick];
                  if (n > 0) begin
                     e = block_map[v][n-1];
                     if (e.valid) begin
                        o.prev_last_block = e.blk;
                        o.prev_last_valid = 1'b1;
                     end
                  end
                  block_map[v][n] = {1'b1, pool[pick]};
                  vol_blocks[v]   = n + 1;
                  free_blocks--;
                  pool[pick] = pool[free_blocks];
                  o.new_logical_index = BlockW'(n);
               end
            end
            rpba_pkg::OpRelease: begin
               if (!vol_ok) begin
                  o.status = rpba_pkg::StBadVolume;
               end else if (vol_blocks[v] == 0) begin
                  o.status = rpba_pkg::StVolEmpty;
               end else if (free_blocks >= eff) begin
                  o.status = rpba_pkg::StIllegal;
               end else begin
                  // pop the tail slot, unmapped tails are just dropped
                  n = vol_blocks[v] - 1;
                  if (n >= MaxBlocks) n = MaxBlocks - 1;
                  e = block_map[v][n];
                  if (e.valid) begin
                     pool[free_blocks] = e.blk;
                     free_blocks++;
                     o.result_block = e.blk;
                  end else begin
                     o.status = rpba_pkg::StUnmapped;
                  end
                  block_map[v][n] = '0;
                  vol_blocks[v]   = n;
                  if (n > 0) begin
                     e = block_map[v][n-1];
                     if (e.valid) begin
                        o.prev_last_block = e.blk;
                        o.prev_last_valid = 1'b1;
                     end
                  end
               end
            end
            default: begin
               if (!vol_ok) begin
                  o.status = rpba_pkg::StBadVolume;
               end else if (!slot_ok) begin
                  o.status = rpba_pkg::StIllegal;
               end else begin
                  e = block_map[v][slot];
                  if (!e.valid) begin
                     o.status = rpba_pkg::StUnmapped;
                  end else begin
                     o.result_block  = e.blk;
                     prod            = 64'(start_reg) + 64'(e.blk) * 64'(secs_reg);
                     o.sector_offset = prod[OffsetW-1:0];
                  end
               end
            end
         endcase
         o.pool_count   = CountW'(free_blocks);
         o.volume_count = vol_ok ? CountW'(vol_blocks[v]) : '0;
         return o;
      endfunction

      function void note_request(alloc_request_type r);
         awaited.push_back(predict_outcome(r));
      endfunction

      function void check_result(alloc_outcome_type got);
         alloc_outcome_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response beat with nothing outstanding: %p", got);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response mismatch (status blk last lvalid idx offset pool vol)");
               $display("  expected %0d %0d %0d %0d %0d %h %0d %0d", want.status,
                        want.result_block, want.prev_last_block, want.prev_last_valid,
                        want.new_logical_index, want.sector_offset, want.pool_count,
                        want.volume_count);
               $display("  actual   %0d %0d %0d %0d %0d %h %0d %0d", got.status,
                        got.result_block, got.prev_last_block, got.prev_last_valid,
                        got.new_logical_index, got.sector_offset, got.pool_count,
                        got.volume_count);
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   logic [WordW-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op = rpba_pkg::OpRecord;
   logic [VolW-1:0]      req_volume = '0;
   logic [BlockW-1:0]    req_phys_block = '0;
   logic                 req_claimed = 1'b0;
   logic signed [WordW-1:0] req_logical_number = '0;
   logic                 req_is_last = 1'b0;
   logic [WordW-1:0]     req_random_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [2:0]           rsp_status;
   logic [BlockW-1:0]    rsp_result_block;
   logic [BlockW-1:0]    rsp_prev_last_block;
   logic                 rsp_prev_last_valid;
   logic [BlockW-1:0]    rsp_new_logical_index;
   logic [OffsetW-1:0]   rsp_sector_offset;
   logic [CountW-1:0]    rsp_pool_count;
   logic [CountW-1:0]    rsp_volume_count;

   alloc_scoreboard sb = new();
   bit              quiet = 1'b0;
   int unsigned     stall_left = 0;
   int unsigned     cycles = 0;

   random_pick_block_allocator_top dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // response side: check each beat, then stall for a drawn number of cycles
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         sb.check_result({rsp_status, rsp_result_block, rsp_prev_last_block,
                          rsp_prev_last_valid, rsp_new_logical_index, rsp_sector_offset,
                          rsp_pool_count, rsp_volume_count});
         stall_left = quiet ? 0 : $urandom_range(0, 5);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // write all three registers in turn
   task automatic configure(input logic [10:0] blocks, input logic [31:0] start,
                            input logic [31:0] secs);
      csr_we    <= 1'b1;
      csr_index <= rpba_pkg::CsrTotalBlocks;
      csr_wdata <= WordW'(blocks);
      @(posedge clock);
      csr_index <= rpba_pkg::CsrDataStart;
      csr_wdata <= start;
      @(posedge clock);
      csr_index <= rpba_pkg::CsrBlockSecs;
      csr_wdata <= secs;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_config(blocks, start, secs);
   endtask

   // present one beat, wait for it to be taken, then maybe idle a while
   task automatic send_request(input alloc_request_type r);
      int unsigned gap;
      req_op             <= r.op;
      req_volume         <= r.volume;
      req_phys_block     <= r.phys_block;
      req_claimed        <= r.claimed;
      req_logical_number <= r.logical_number;
      req_is_last        <= r.is_last;
      req_random_word    <= r.random_word;
      req_valid          <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off until every owed response has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic alloc_request_type make_request(logic [1:0] op, int unsigned vol,
                                                      int unsigned blk, bit claimed,
                                                      int slot, bit last,
                                                      logic [31:0] rnd);
      alloc_request_type r;
      r.op             = op;
      r.volume         = VolW'(vol);
      r.phys_block     = BlockW'(blk);
      r.claimed        = claimed;
      r.logical_number = slot;
      r.is_last        = last;
      r.random_word    = rnd;
      return r;
   endfunction

   // mostly well-formed traffic aimed at the current store size, some noise
   function automatic alloc_request_type draw_request();
      alloc_request_type r;
      int unsigned       span;
      int unsigned       bound;
      int unsigned       mix;
      span = sb.effective_total();
      r.volume     = VolW'($urandom_range(0, MaxVolumes - 1));
      r.is_last    = 1'($urandom_range(0, 1));
      r.phys_block = ($urandom_range(0, 7) == 0) ? BlockW'($urandom) :
                                                   BlockW'($urandom_range(0, span - 1));
      case ($urandom_range(0, 15))
         0: r.random_word = '0;
         1: r.random_word = '1;
         default: r.random_word = $urandom;
      endcase
      mix = $urandom_range(0, 99);
      if (sb.free_blocks == 0 && mix < 50) mix = 0;
      if (mix < 22) begin
         r.op      = rpba_pkg::OpRecord;
         r.claimed = 1'b0;
      end else if (mix < 32) begin
         r.op      = rpba_pkg::OpRecord;
         r.claimed = 1'b1;
      end else if (mix < 60) begin
         r.op      = rpba_pkg::OpAlloc;
         r.claimed = 1'($urandom_range(0, 1));
      end else if (mix < 80) begin
         r.op      = rpba_pkg::OpRelease;
         r.claimed = 1'($urandom_range(0, 1));
      end else begin
         r.op      = rpba_pkg::OpLookup;
         r.claimed = 1'($urandom_range(0, 1));
      end
      // slot: usually in range, sometimes just past it, negative or anything
      bound = span;
      if (r.op == rpba_pkg::OpLookup && sb.vol_blocks[r.volume] > 0 &&
          sb.vol_blocks[r.volume] < span)
         bound = sb.vol_blocks[r.volume];
      case ($urandom_range(0, 15))
         0: r.logical_number = $urandom;
         1: r.logical_number = span + $urandom_range(0, 2);
         2: r.logical_number = -int'($urandom_range(1, 4));
         default: r.logical_number = $urandom_range(0, bound - 1);
      endcase
      // pure noise
      if ($urandom_range(0, 19) == 0) begin
         r.op             = 2'($urandom);
         r.claimed        = 1'($urandom);
         r.phys_block     = BlockW'($urandom);
         r.logical_number = $urandom;
      end
      return r;
   endfunction

   task automatic run_phase(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
         send_request(draw_request());
         if (i % 97 == 96) drain_results();
      end
      drain_results();
   endtask

   // stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      configure(11'd1024, '1, '1);

      // empty pool, empty volume, unmapped and out-of-range lookups
      send_request(make_request(rpba_pkg::OpAlloc, 0, 0, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRelease, 0, 0, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpLookup, 0, 0, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpLookup, 0, 0, 1, -1, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpLookup, 0, 0, 0, 1024, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpLookup, 0, 0, 0, 32'h7FFF_FFFF, 1, 32'h0));
      // stock the pool with the extreme blocks, then pick both ends
      send_request(make_request(rpba_pkg::OpRecord, 2, 1023, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRecord, 2, 0, 0, 0, 1, 32'hFFFF_FFFF));
      send_request(make_request(rpba_pkg::OpAlloc, 7, 0, 0, 0, 0, 32'hFFFF_FFFF));
      send_request(make_request(rpba_pkg::OpAlloc, 7, 0, 0, 0, 0, 32'h0));
      // widest sector offset
      send_request(make_request(rpba_pkg::OpLookup, 7, 0, 0, 1, 0, 32'h0));
      // claimed records: fresh slot, occupied slot, bad slots
      send_request(make_request(rpba_pkg::OpRecord, 3, 1023, 1, 5, 1, 32'h0));
      send_request(make_request(rpba_pkg::OpRecord, 3, 2, 1, 5, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRecord, 3, 2, 1, -5, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRecord, 3, 2, 1, 1024, 0, 32'h0));
      // release of an unmapped tail slot
      send_request(make_request(rpba_pkg::OpRelease, 3, 0, 0, 0, 0, 32'h0));
      // allocate over a slot that a record already mapped
      send_request(make_request(rpba_pkg::OpRecord, 4, 9, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRecord, 3, 7, 1, 1, 1, 32'h0));
      send_request(make_request(rpba_pkg::OpAlloc, 3, 0, 0, 0, 0, 32'h8000_0000));
      // releases that expose a new last block, then empty the volume
      send_request(make_request(rpba_pkg::OpRelease, 7, 0, 0, 0, 0, 32'h0));
      send_request(make_request(rpba_pkg::OpRelease, 7, 0, 0, 0, 0, 32'h0));
      // stale slot beyond the volume count
      send_request(make_request(rpba_pkg::OpLookup, 3, 0, 0, 5, 0, 32'h0));
      run_phase(150);

      configure(11'd16, 32'd0, 32'd1);
      run_phase(300);
      configure(11'd1, 32'd123, 32'd7);
      run_phase(100);
      configure(11'd64, $urandom, $urandom);
      run_phase(300);
      configure(11'd0, 32'd0, '1);
      run_phase(60);
      configure(11'd2047, $urandom, 32'd1);
      run_phase(200);
      configure(11'd8, '1, 32'd1);
      run_phase(200);
      configure(11'd1024, $urandom, $urandom);
      run_phase(240);

      // let any stray beat show up
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
